FILE: design/sdcu_pkg.sv
// Shared types, register indexes, reset defaults and address tables for the Super I/O decoder.
`default_nettype none

package sdcu_pkg;

   // Register indexes with special meaning.
   localparam logic [4:0] IDX_FER     = 5'h00;
   localparam logic [4:0] IDX_FAR     = 5'h01;
   localparam logic [4:0] IDX_PTR     = 5'h02;
   localparam logic [4:0] IDX_SID     = 5'h08;
   localparam logic [4:0] IDX_ASC     = 5'h09;
   localparam logic [4:0] IDX_GPBA    = 5'h0f;
   localparam logic [4:0] IDX_GPEN    = 5'h12;
   localparam logic [4:0] IDX_LPTBA   = 5'h19;
   localparam logic [4:0] IDX_PNP0    = 5'h1b;
   localparam logic [4:0] IDX_PNP1    = 5'h1c;
   localparam logic [4:0] READ_LIMIT  = 5'h1c;

   // Special data values.
   localparam logic [7:0] FER_MAGIC   = 8'h08;
   localparam logic [7:0] FER_REMAP   = 8'h4b;
   localparam logic [7:0] FER_MASK    = 8'h5f;
   localparam logic [7:0] LPTBA_DFLT  = 8'hef;
   localparam logic [7:0] SID_VALUE   = 8'h70;
   localparam logic [7:0] OPEN_BUS    = 8'hff;

   // Decoded base addresses.
   localparam logic [9:0] LPT_PRI     = 10'h378;
   localparam logic [9:0] LPT_SEC     = 10'h278;
   localparam logic [9:0] COM1_BASE   = 10'h3f8;
   localparam logic [9:0] COM2_BASE   = 10'h2f8;
   localparam logic [9:0] FDC_PRI     = 10'h3f0;
   localparam logic [9:0] FDC_SEC     = 10'h370;
   localparam logic [2:0] IRQ_THREE   = 3'd3;
   localparam logic [2:0] IRQ_FOUR    = 3'd4;

   // One bus access.
   typedef struct packed {
      logic       func;
      logic       port_sel;
      logic [7:0] write_data;
   } req_type;

   // One result.
   typedef struct packed {
      logic [7:0] read_data;
      logic [9:0] lpt_base;
      logic [9:0] uart_one_base;
      logic [2:0] uart_one_irq;
      logic [9:0] uart_two_base;
      logic [2:0] uart_two_irq;
      logic [9:0] fdc_base;
      logic       fdc_enhanced;
      logic       densel_polarity;
      logic [9:0] gpio_base;
      logic [1:0] gpio_enables;
   } rsp_type;

   // Registers that feed the resource decode.
   typedef struct packed {
      logic [7:0] fer;
      logic [7:0] far;
      logic [7:0] ptr;
      logic [7:0] asc;
      logic [7:0] gpba;
      logic [7:0] gpen;
      logic [7:0] lptba;
      logic [7:0] pnp0;
      logic [7:0] pnp1;
   } dec_regs_type;

   // Power-on value of each configuration register.
   function automatic logic [7:0] reset_value(input logic [4:0] idx);
      logic [7:0] val;
      case (idx)
         5'h00:   val = 8'h0b;
         5'h01:   val = 8'h01;
         5'h03:   val = 8'h01;
         5'h05:   val = 8'h0d;
         5'h08:   val = 8'h70;
         5'h09:   val = 8'hc0;
         5'h0b:   val = 8'h80;
         5'h0f:   val = 8'h1e;
         5'h12:   val = 8'h30;
         5'h19:   val = 8'hef;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   // Third UART address choice, selected by the high bits of the address register.
   function automatic logic [9:0] uart_third(input logic [1:0] hi);
      logic [9:0] val;
      case (hi)
         2'd0:    val = 10'h3e8;
         2'd1:    val = 10'h338;
         2'd2:    val = 10'h2e8;
         default: val = 10'h220;
      endcase
      return val;
   endfunction

   // Fourth UART address choice.
   function automatic logic [9:0] uart_fourth(input logic [1:0] hi);
      logic [9:0] val;
      case (hi)
         2'd0:    val = 10'h2e8;
         2'd1:    val = 10'h238;
         2'd2:    val = 10'h2e0;
         default: val = 10'h228;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: design/sdcu_if.sv
// Valid/ready channel interfaces for bus accesses and results.
`default_nettype none

interface sdcu_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       port_sel;
   logic [7:0] write_data;

   modport source (output valid, output func, output port_sel, output write_data,
                   input ready);
   modport sink   (input valid, input func, input port_sel, input write_data,
                   output ready);
endinterface

interface sdcu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic [9:0] lpt_base;
   logic [9:0] uart_one_base;
   logic [2:0] uart_one_irq;
   logic [9:0] uart_two_base;
   logic [2:0] uart_two_irq;
   logic [9:0] fdc_base;
   logic       fdc_enhanced;
   logic       densel_polarity;
   logic [9:0] gpio_base;
   logic [1:0] gpio_enables;

   modport source (output valid, output read_data, output lpt_base, output uart_one_base,
                   output uart_one_irq, output uart_two_base, output uart_two_irq,
                   output fdc_base, output fdc_enhanced, output densel_polarity,
                   output gpio_base, output gpio_enables, input ready);
   modport sink   (input valid, input read_data, input lpt_base, input uart_one_base,
                   input uart_one_irq, input uart_two_base, input uart_two_irq,
                   input fdc_base, input fdc_enhanced, input densel_polarity,
                   input gpio_base, input gpio_enables, output ready);
endinterface

`default_nettype wire

FILE: design/sdcu_regfile.sv
// Index/data access state machine and configuration register file.
`default_nettype none

module sdcu_regfile #(
   parameter int NUM_REGS = 29
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire sdcu_pkg::req_type     req,
   output      logic [7:0]            read_data,
   output      sdcu_pkg::dec_regs_type dec_next
);

   localparam logic [5:0] NumRegsW = 6'(NUM_REGS);

   logic [4:0] index_ff, index_in;
   logic       armed_ff, armed_in;
   logic [7:0] file_ff [NUM_REGS];
   logic [7:0] file_in [NUM_REGS];
   logic [7:0] wval;
   logic       store_ok;

   // Value an armed data write would store, after the register 0 remap and mask.
   always_comb begin
      wval = req.write_data;
      if (index_ff == sdcu_pkg::IDX_FER) begin
         if (req.write_data == sdcu_pkg::FER_MAGIC) begin
            wval = sdcu_pkg::FER_REMAP;
         end
         wval = wval & sdcu_pkg::FER_MASK;
      end
   end

   // Armed writes are dropped beyond the file, at the ID register and at a locked base.
   assign store_ok = ({1'b0, index_ff} < NumRegsW) && (index_ff != sdcu_pkg::IDX_SID) &&
                     !((index_ff == sdcu_pkg::IDX_LPTBA) &&
                       !file_ff[sdcu_pkg::IDX_PNP0][6]);

   // Next state of index, unlock and register file for the access in flight.
   always_comb begin
      index_in = index_ff;
      armed_in = armed_ff;
      file_in  = file_ff;
      if (accept) begin
         if (!req.func) begin
            armed_in = 1'b0;
         end else if (!req.port_sel) begin
            index_in = req.write_data[4:0];
            armed_in = 1'b0;
         end else if (!armed_ff) begin
            armed_in = 1'b1;
         end else begin
            armed_in = 1'b0;
            if (store_ok) begin
               file_in[index_ff] = wval;
               if ((index_ff == sdcu_pkg::IDX_PNP0) &&
                   (((file_ff[sdcu_pkg::IDX_PNP0] ^ wval) & 8'h70) != 8'h00) &&
                   !wval[6]) begin
                  file_in[sdcu_pkg::IDX_LPTBA] = sdcu_pkg::LPTBA_DFLT;
               end
            end
         end
      end
   end

   // Read data for the access in flight.
   always_comb begin
      read_data = 8'h00;
      if (!req.func) begin
         if (!req.port_sel) begin
            read_data = {3'b000, index_ff};
         end else if (index_ff == sdcu_pkg::IDX_SID) begin
            read_data = sdcu_pkg::SID_VALUE;
         end else if (index_ff < sdcu_pkg::READ_LIMIT) begin
            read_data = file_ff[index_ff];
         end else begin
            read_data = sdcu_pkg::OPEN_BUS;
         end
      end
   end

   // Registers the decode looks at, taken after this access.
   always_comb begin
      dec_next.fer   = file_in[sdcu_pkg::IDX_FER];
      dec_next.far   = file_in[sdcu_pkg::IDX_FAR];
      dec_next.ptr   = file_in[sdcu_pkg::IDX_PTR];
      dec_next.asc   = file_in[sdcu_pkg::IDX_ASC];
      dec_next.gpba  = file_in[sdcu_pkg::IDX_GPBA];
      dec_next.gpen  = file_in[sdcu_pkg::IDX_GPEN];
      dec_next.lptba = file_in[sdcu_pkg::IDX_LPTBA];
      dec_next.pnp0  = file_in[sdcu_pkg::IDX_PNP0];
      dec_next.pnp1  = file_in[sdcu_pkg::IDX_PNP1];
   end

   // State registers; reset loads the documented defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= 5'd0;
         armed_ff <= 1'b0;
         for (int i = 0; i < NUM_REGS; i++) begin
            file_ff[i] <= sdcu_pkg::reset_value(5'(i));
         end
      end else begin
         index_ff <= index_in;
         armed_ff <= armed_in;
         file_ff  <= file_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/sdcu_decode.sv
// Resource decode: turns the configuration registers into base addresses and IRQs.
`default_nettype none

module sdcu_decode (
   input  wire sdcu_pkg::dec_regs_type regs,
   input  wire logic [7:0]             read_data,
   output      sdcu_pkg::rsp_type      rsp
);

   logic [2:0] irq_one_fer, irq_one_pnp, irq_two_fer, irq_two_pnp;
   logic [9:0] lpt_base;
   logic [9:0] uart_one_base;
   logic [9:0] uart_two_base;
   logic [9:0] fdc_base;

   // Parallel port base.
   always_comb begin
      lpt_base = 10'd0;
      if (regs.fer[0]) begin
         if (regs.pnp0[4]) begin
            lpt_base = regs.pnp0[5] ? sdcu_pkg::LPT_SEC : sdcu_pkg::LPT_PRI;
         end else begin
            case (regs.far[1:0])
               2'd0:    lpt_base = sdcu_pkg::LPT_PRI;
               2'd1:    lpt_base = {regs.lptba, 2'b00};
               2'd2:    lpt_base = sdcu_pkg::LPT_SEC;
               default: lpt_base = 10'd0;
            endcase
         end
      end
   end

   // UART bases from the two-bit selects and the shared high-address field.
   always_comb begin
      uart_one_base = 10'd0;
      if (regs.fer[1]) begin
         case (regs.far[3:2])
            2'd0:    uart_one_base = sdcu_pkg::COM1_BASE;
            2'd1:    uart_one_base = sdcu_pkg::COM2_BASE;
            2'd2:    uart_one_base = sdcu_pkg::uart_third(regs.far[7:6]);
            default: uart_one_base = sdcu_pkg::uart_fourth(regs.far[7:6]);
         endcase
      end
      uart_two_base = 10'd0;
      if (regs.fer[2]) begin
         case (regs.far[5:4])
            2'd0:    uart_two_base = sdcu_pkg::COM1_BASE;
            2'd1:    uart_two_base = sdcu_pkg::COM2_BASE;
            2'd2:    uart_two_base = sdcu_pkg::uart_third(regs.far[7:6]);
            default: uart_two_base = sdcu_pkg::uart_fourth(regs.far[7:6]);
         endcase
      end
   end

   // UART IRQs: plug-and-play routing overrides the address-derived default.
   assign irq_one_fer = regs.far[2] ? sdcu_pkg::IRQ_THREE : sdcu_pkg::IRQ_FOUR;
   assign irq_two_fer = regs.far[4] ? sdcu_pkg::IRQ_THREE : sdcu_pkg::IRQ_FOUR;
   assign irq_one_pnp = regs.pnp1[2] ? sdcu_pkg::IRQ_FOUR : sdcu_pkg::IRQ_THREE;
   assign irq_two_pnp = regs.pnp1[6] ? sdcu_pkg::IRQ_FOUR : sdcu_pkg::IRQ_THREE;

   // Floppy controller is off when disabled or powered down.
   assign fdc_base = (!regs.fer[3] || regs.ptr[0]) ? 10'd0 :
                     (regs.fer[5] ? sdcu_pkg::FDC_SEC : sdcu_pkg::FDC_PRI);

   // Assemble the result: read data, decoded bases, mode bits and GPIO decode.
   always_comb begin
      rsp.read_data       = read_data;
      rsp.lpt_base        = lpt_base;
      rsp.uart_one_base   = uart_one_base;
      rsp.uart_one_irq    = regs.pnp1[0] ? irq_one_pnp : irq_one_fer;
      rsp.uart_two_base   = uart_two_base;
      rsp.uart_two_irq    = regs.pnp1[0] ? irq_two_pnp : irq_two_fer;
      rsp.fdc_base        = fdc_base;
      rsp.fdc_enhanced    = regs.asc[2];
      rsp.densel_polarity = regs.asc[6];
      rsp.gpio_base       = {regs.gpba, 2'b00};
      rsp.gpio_enables    = regs.gpen[5:4];
   end

endmodule

`default_nettype wire

FILE: design/superio_config_decoder_unit.sv
// Top level of the Super I/O configuration decoder.
//
// Usage: each transfer on req_bus is one bus access: func selects read or write
// and port_sel selects the index port or the data port. An index write selects
// a register; data writes must come in pairs (the first arms the unlock, the
// second stores) and any read disarms the unlock. Each access produces exactly
// one transfer on rsp_bus carrying the read byte (zero on writes) and the
// resource decode of the register file as it stands after that access.
// The access is applied to the register file and the result register is loaded
// at the accepting edge. Throughput is one access per cycle while rsp_bus takes
// results, set by the single result register; req_bus.ready stays high while the
// result register is empty or is being drained in the same cycle.
// When rsp_bus stalls, the held result stays stable and one more access is not
// taken until it drains. Synchronous reset empties the result register, clears
// the index and the unlock, and loads the register defaults.
`default_nettype none

module superio_config_decoder_unit #(
   parameter int NUM_REGS = 29
) (
   input wire logic    clock,
   input wire logic    reset,
   sdcu_req_if.sink    req_bus,
   sdcu_rsp_if.source  rsp_bus
);

   sdcu_pkg::req_type      req;
   sdcu_pkg::dec_regs_type dec_next;
   sdcu_pkg::rsp_type      rsp_in;
   sdcu_pkg::rsp_type      rsp_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   accept;
   logic [7:0]             read_data;

   // Handshake: take an access whenever the result register can be freed.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign req = '{func:       req_bus.func,
                  port_sel:   req_bus.port_sel,
                  write_data: req_bus.write_data};

   sdcu_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .read_data (read_data),
      .dec_next  (dec_next)
   );

   sdcu_decode u_decode (
      .regs      (dec_next),
      .read_data (read_data),
      .rsp       (rsp_in)
   );

   // Result register.
   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result transfer outputs.
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.read_data       = rsp_ff.read_data;
   assign rsp_bus.lpt_base        = rsp_ff.lpt_base;
   assign rsp_bus.uart_one_base   = rsp_ff.uart_one_base;
   assign rsp_bus.uart_one_irq    = rsp_ff.uart_one_irq;
   assign rsp_bus.uart_two_base   = rsp_ff.uart_two_base;
   assign rsp_bus.uart_two_irq    = rsp_ff.uart_two_irq;
   assign rsp_bus.fdc_base        = rsp_ff.fdc_base;
   assign rsp_bus.fdc_enhanced    = rsp_ff.fdc_enhanced;
   assign rsp_bus.densel_polarity = rsp_ff.densel_polarity;
   assign rsp_bus.gpio_base       = rsp_ff.gpio_base;
   assign rsp_bus.gpio_enables    = rsp_ff.gpio_enables;

endmodule

`default_nettype wire

FILE: design/sdcu_checker.sv
// Port-level checks for the Super I/O configuration decoder, bound to the top level.
`default_nettype none

module sdcu_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       req_func,
   input wire logic       req_port_sel,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_read_data
);

   // Reset empties the result register.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A held result keeps its data while the receiver stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("stalled result changed");

   // Every write transfer yields one result with zero read data in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |=> rsp_valid && (rsp_read_data == 8'h00))
      else $error("write result missing or nonzero");

   // An index port read returns a five-bit index.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_func && !req_port_sel |=>
      rsp_valid && (rsp_read_data[7:5] == 3'b000))
      else $error("index read out of range");

   // The input side is never blocked while the result register is empty.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind superio_config_decoder_unit sdcu_checker u_sdcu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_func      (req_bus.func),
   .req_port_sel  (req_bus.port_sel),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_read_data (rsp_bus.read_data)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for the Super I/O decoder: directed table, then random accesses.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_REGS       = 29;
   localparam int RANDOM_ITEMS   = 750;
   localparam int DIRECTED_N     = 33;
   localparam int CALM_TAIL      = 100;
   localparam int LONG_HOLD      = 40;
   localparam int HOLD_AFTER     = 200;
   localparam int PAUSE_AT       = 450;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int SETTLE_CYCLES  = 4;
   localparam int MAX_REPORTS    = 10;

   // Access kinds and port selects.
   localparam logic ACC_READ   = 1'b0;
   localparam logic ACC_WRITE  = 1'b1;
   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // Parallel port mode bits of the first plug-and-play register.
   localparam logic [7:0] PNP0_LPT_BITS = 8'h70;
   localparam logic [4:0] IDX_TOP       = 5'h1f;

   // One stimulus row; typed rows carry a read byte that is known up front.
   typedef struct packed {
      logic       func;
      logic       port_sel;
      logic [7:0] write_data;
      logic       typed;
      logic [7:0] typed_read;
   } access_row_type;

   logic clock;
   logic reset;

   sdcu_req_if req_bus ();
   sdcu_rsp_if rsp_bus ();

   superio_config_decoder_unit #(
      .NUM_REGS(NUM_REGS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Directed accesses: reset values, the read-only and out-of-range registers, the
   // magic value and mask of the enable register, read disarming the unlock, and the
   // lock and restore of the parallel port base register.
   access_row_type directed_rows [DIRECTED_N] = '{
      '{ACC_READ,  PORT_INDEX, 8'h5a, 1'b1, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, 8'h0b},
      '{ACC_WRITE, PORT_INDEX, 8'he8, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::SID_VALUE},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h55, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_INDEX, 8'hff, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'hff, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::OPEN_BUS},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_FER}, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'haa, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  sdcu_pkg::FER_MAGIC, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::FER_REMAP},
      '{ACC_WRITE, PORT_DATA,  8'hff, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'hff, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::FER_MASK},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_LPTBA}, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::LPTBA_DFLT},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_PNP0}, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  PNP0_LPT_BITS, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_LPTBA}, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h12, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_PNP0}, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_DATA,  8'h00, 1'b0, 8'h00},
      '{ACC_WRITE, PORT_INDEX, {3'b000, sdcu_pkg::IDX_LPTBA}, 1'b0, 8'h00},
      '{ACC_READ,  PORT_DATA,  8'h00, 1'b1, sdcu_pkg::LPTBA_DFLT}
   };

   access_row_type    access_list [$];
   sdcu_pkg::rsp_type expected_results [$];

   // Shadow of the decoder state.
   logic [4:0] shadow_index;
   logic       shadow_unlock;
   logic [7:0] shadow_regs [0:31];

   int  accepted_n;
   int  results_checked;
   int  mismatch_count;
   int  quiet_cycles;
   bit  quiet_tail;
   bit  long_hold_done;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Register read as the decode sees it; slots past the file read as zero.
   function automatic logic [7:0] shadow_reg(input logic [4:0] idx);
      return (int'(idx) < NUM_REGS) ? shadow_regs[idx] : 8'h00;
   endfunction

   // UART interrupt: plug-and-play select when enabled, otherwise the legacy bit.
   function automatic logic [2:0] uart_irq(input bit second);
      logic [7:0] far_val;
      logic [7:0] pnp1_val;
      logic       legacy_bit;
      logic       pnp_bit;
      far_val    = shadow_reg(sdcu_pkg::IDX_FAR);
      pnp1_val   = shadow_reg(sdcu_pkg::IDX_PNP1);
      legacy_bit = second ? far_val[4] : far_val[2];
      pnp_bit    = second ? pnp1_val[6] : pnp1_val[2];
      if (pnp1_val[0])
         return pnp_bit ? sdcu_pkg::IRQ_FOUR : sdcu_pkg::IRQ_THREE;
      return legacy_bit ? sdcu_pkg::IRQ_THREE : sdcu_pkg::IRQ_FOUR;
   endfunction

   // UART base from the enable bit and the two-bit address choice.
   function automatic logic [9:0] uart_base(input bit second);
      logic [7:0] far_val;
      logic [7:0] fer_val;
      logic [1:0] choice;
      logic [9:0] base;
      far_val = shadow_reg(sdcu_pkg::IDX_FAR);
      fer_val = shadow_reg(sdcu_pkg::IDX_FER);
      choice  = second ? far_val[5:4] : far_val[3:2];
      if (!(second ? fer_val[2] : fer_val[1]))
         return 10'h000;
      case (choice)
         2'd0: base = sdcu_pkg::COM1_BASE;
         2'd1: base = sdcu_pkg::COM2_BASE;
         2'd2: begin
            case (far_val[7:6])
               2'd0:    base = 10'h3e8;
               2'd1:    base = 10'h338;
               2'd2:    base = 10'h2e8;
               default: base = 10'h220;
            endcase
         end
         default: begin
            case (far_val[7:6])
               2'd0:    base = 10'h2e8;
               2'd1:    base = 10'h238;
               2'd2:    base = 10'h2e0;
               default: base = 10'h228;
            endcase
         end
      endcase
      return base;
   endfunction

   // Apply one accepted access to the shadow state and return the result it causes.
   function automatic sdcu_pkg::rsp_type decode_access(input sdcu_pkg::req_type acc);
      sdcu_pkg::rsp_type res;
      logic [4:0]        idx;
      logic [7:0]        value;
      logic [7:0]        old_value;
      logic [7:0]        fer_val;
      logic [7:0]        pnp0_val;
      logic [7:0]        asc_val;
      logic [7:0]        gpen_val;
      bit                dropped;
      idx = shadow_index;
      res = '0;

      // Bus access: index select, data write with the two-step unlock, or read.
      if (acc.func == ACC_WRITE) begin
         if (acc.port_sel == PORT_INDEX) begin
            shadow_index  = acc.write_data[4:0];
            shadow_unlock = 1'b0;
         end else if (!shadow_unlock) begin
            shadow_unlock = 1'b1;
         end else begin
            shadow_unlock = 1'b0;
            value    = acc.write_data;
            pnp0_val = shadow_reg(sdcu_pkg::IDX_PNP0);
            if (idx == sdcu_pkg::IDX_FER && value == sdcu_pkg::FER_MAGIC)
               value = sdcu_pkg::FER_REMAP;
            dropped = (idx == sdcu_pkg::IDX_LPTBA && !pnp0_val[6]) ||
                      int'(idx) >= NUM_REGS || idx == sdcu_pkg::IDX_SID;
            if (!dropped) begin
               if (idx == sdcu_pkg::IDX_FER)
                  value = value & sdcu_pkg::FER_MASK;
               old_value         = shadow_regs[idx];
               shadow_regs[idx]  = value;
               if (idx == sdcu_pkg::IDX_PNP0 &&
                   ((old_value ^ value) & PNP0_LPT_BITS) != 8'h00 && !value[6])
                  shadow_regs[sdcu_pkg::IDX_LPTBA] = sdcu_pkg::LPTBA_DFLT;
            end
         end
      end else begin
         shadow_unlock = 1'b0;
         if (acc.port_sel == PORT_INDEX)
            res.read_data = {3'b000, idx};
         else if (idx == sdcu_pkg::IDX_SID)
            res.read_data = sdcu_pkg::SID_VALUE;
         else if (idx < sdcu_pkg::READ_LIMIT)
            res.read_data = shadow_reg(idx);
         else
            res.read_data = sdcu_pkg::OPEN_BUS;
      end

      // Resource decode of the register file after the access.
      fer_val  = shadow_reg(sdcu_pkg::IDX_FER);
      pnp0_val = shadow_reg(sdcu_pkg::IDX_PNP0);
      asc_val  = shadow_reg(sdcu_pkg::IDX_ASC);
      gpen_val = shadow_reg(sdcu_pkg::IDX_GPEN);
      if (!fer_val[0])
         res.lpt_base = 10'h000;
      else if (pnp0_val[4])
         res.lpt_base = pnp0_val[5] ? sdcu_pkg::LPT_SEC : sdcu_pkg::LPT_PRI;
      else begin
         case (shadow_reg(sdcu_pkg::IDX_FAR) & 8'h03)
            8'h00:   res.lpt_base = sdcu_pkg::LPT_PRI;
            8'h01:   res.lpt_base = {shadow_reg(sdcu_pkg::IDX_LPTBA), 2'b00};
            8'h02:   res.lpt_base = sdcu_pkg::LPT_SEC;
            default: res.lpt_base = 10'h000;
         endcase
      end
      res.uart_one_base = uart_base(1'b0);
      res.uart_one_irq  = uart_irq(1'b0);
      res.uart_two_base = uart_base(1'b1);
      res.uart_two_irq  = uart_irq(1'b1);
      if (!fer_val[3] || shadow_reg(sdcu_pkg::IDX_PTR) & 8'h01)
         res.fdc_base = 10'h000;
      else
         res.fdc_base = fer_val[5] ? sdcu_pkg::FDC_SEC : sdcu_pkg::FDC_PRI;
      res.fdc_enhanced    = asc_val[2];
      res.densel_polarity = asc_val[6];
      res.gpio_base       = {shadow_reg(sdcu_pkg::IDX_GPBA), 2'b00};
      res.gpio_enables    = gpen_val[5:4];
      return res;
   endfunction

   // Append one untyped access to the stimulus list.
   function automatic void add_access(input logic f, input logic p, input logic [7:0] d);
      access_row_type row;
      row.func       = f;
      row.port_sel   = p;
      row.write_data = d;
      row.typed      = 1'b0;
      row.typed_read = 8'h00;
      access_list.push_back(row);
   endfunction

   // Register index, weighted toward the ones with special behavior.
   function automatic logic [4:0] pick_index();
      logic [4:0] idx;
      if ($urandom_range(0, 1) == 0)
         return 5'($urandom_range(0, 31));
      case ($urandom_range(0, 11))
         0:       idx = sdcu_pkg::IDX_FER;
         1:       idx = sdcu_pkg::IDX_FAR;
         2:       idx = sdcu_pkg::IDX_PTR;
         3:       idx = sdcu_pkg::IDX_SID;
         4:       idx = sdcu_pkg::IDX_ASC;
         5:       idx = sdcu_pkg::IDX_GPBA;
         6:       idx = sdcu_pkg::IDX_GPEN;
         7:       idx = sdcu_pkg::IDX_LPTBA;
         8:       idx = sdcu_pkg::IDX_PNP0;
         9:       idx = sdcu_pkg::IDX_PNP1;
         10:      idx = sdcu_pkg::READ_LIMIT;
         default: idx = IDX_TOP;
      endcase
      return idx;
   endfunction

   // Compare one result field by field against the oldest expectation.
   function automatic void check_result(input sdcu_pkg::rsp_type want,
                                        input sdcu_pkg::rsp_type got);
      string diffs;
      diffs = "";
      if (got.read_data !== want.read_data)
         diffs = {diffs, $sformatf(" read_data exp %h got %h", want.read_data, got.read_data)};
      if (got.lpt_base !== want.lpt_base)
         diffs = {diffs, $sformatf(" lpt_base exp %h got %h", want.lpt_base, got.lpt_base)};
      if (got.uart_one_base !== want.uart_one_base)
         diffs = {diffs, $sformatf(" uart_one_base exp %h got %h",
                                   want.uart_one_base, got.uart_one_base)};
      if (got.uart_one_irq !== want.uart_one_irq)
         diffs = {diffs, $sformatf(" uart_one_irq exp %0d got %0d",
                                   want.uart_one_irq, got.uart_one_irq)};
      if (got.uart_two_base !== want.uart_two_base)
         diffs = {diffs, $sformatf(" uart_two_base exp %h got %h",
                                   want.uart_two_base, got.uart_two_base)};
      if (got.uart_two_irq !== want.uart_two_irq)
         diffs = {diffs, $sformatf(" uart_two_irq exp %0d got %0d",
                                   want.uart_two_irq, got.uart_two_irq)};
      if (got.fdc_base !== want.fdc_base)
         diffs = {diffs, $sformatf(" fdc_base exp %h got %h", want.fdc_base, got.fdc_base)};
      if (got.fdc_enhanced !== want.fdc_enhanced)
         diffs = {diffs, $sformatf(" fdc_enhanced exp %b got %b",
                                   want.fdc_enhanced, got.fdc_enhanced)};
      if (got.densel_polarity !== want.densel_polarity)
         diffs = {diffs, $sformatf(" densel_polarity exp %b got %b",
                                   want.densel_polarity, got.densel_polarity)};
      if (got.gpio_base !== want.gpio_base)
         diffs = {diffs, $sformatf(" gpio_base exp %h got %h", want.gpio_base, got.gpio_base)};
      if (got.gpio_enables !== want.gpio_enables)
         diffs = {diffs, $sformatf(" gpio_enables exp %b got %b",
                                   want.gpio_enables, got.gpio_enables)};
      if (diffs != "") begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d:%s", results_checked, diffs);
      end
   endfunction

   // Monitor: predict on every accepted access, check every result transfer.
   always @(posedge clock) begin : monitor
      sdcu_pkg::req_type acc;
      sdcu_pkg::rsp_type predicted;
      sdcu_pkg::rsp_type observed;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            acc.func       = req_bus.func;
            acc.port_sel   = req_bus.port_sel;
            acc.write_data = req_bus.write_data;
            predicted      = decode_access(acc);
            if (accepted_n < access_list.size() && access_list[accepted_n].typed)
               predicted.read_data = access_list[accepted_n].typed_read;
            expected_results.push_back(predicted);
            accepted_n++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            observed.read_data       = rsp_bus.read_data;
            observed.lpt_base        = rsp_bus.lpt_base;
            observed.uart_one_base   = rsp_bus.uart_one_base;
            observed.uart_one_irq    = rsp_bus.uart_one_irq;
            observed.uart_two_base   = rsp_bus.uart_two_base;
            observed.uart_two_irq    = rsp_bus.uart_two_irq;
            observed.fdc_base        = rsp_bus.fdc_base;
            observed.fdc_enhanced    = rsp_bus.fdc_enhanced;
            observed.densel_polarity = rsp_bus.densel_polarity;
            observed.gpio_base       = rsp_bus.gpio_base;
            observed.gpio_enables    = rsp_bus.gpio_enables;
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("result %0d arrived with no access pending, read_data %h",
                           results_checked, observed.read_data);
            end else begin
               check_result(expected_results.pop_front(), observed);
            end
            results_checked++;
         end
      end
   end

   // Watchdog: end the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Result side: random stall bursts, one long hold-off, steady in the tail.
   initial begin
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!long_hold_done && results_checked >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && (results_checked / 80) % 4 != 1 &&
                      $urandom_range(0, 3) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Access side: reset, stimulus build, then one transfer per list entry.
   initial begin
      logic [4:0] idx;
      logic [7:0] rnd;
      logic [7:0] value;
      int         kind;
      int         total;

      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= ACC_READ;
      req_bus.port_sel    <= PORT_INDEX;
      req_bus.write_data  <= 8'h00;
      accepted_n          = 0;
      results_checked     = 0;
      mismatch_count      = 0;
      quiet_cycles        = 0;
      quiet_tail          = 1'b0;
      long_hold_done      = 1'b0;

      // Shadow state after reset.
      shadow_index  = 5'd0;
      shadow_unlock = 1'b0;
      for (int i = 0; i < 32; i++)
         shadow_regs[i] = 8'h00;
      shadow_regs[5'h00] = 8'h0b;
      shadow_regs[5'h01] = 8'h01;
      shadow_regs[5'h03] = 8'h01;
      shadow_regs[5'h05] = 8'h0d;
      shadow_regs[5'h08] = 8'h70;
      shadow_regs[5'h09] = 8'hc0;
      shadow_regs[5'h0b] = 8'h80;
      shadow_regs[5'h0f] = 8'h1e;
      shadow_regs[5'h12] = 8'h30;
      shadow_regs[5'h19] = 8'hef;

      for (int i = 0; i < DIRECTED_N; i++)
         access_list.push_back(directed_rows[i]);

      // Random part: mostly complete unlock-and-store sequences, some reads, some noise.
      while (access_list.size() < DIRECTED_N + RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         idx  = pick_index();
         rnd  = 8'($urandom);
         if (kind <= 5) begin
            add_access(ACC_WRITE, PORT_INDEX, {rnd[7:5], idx});
            add_access(ACC_WRITE, PORT_DATA, 8'($urandom));
            // A read between the two data writes breaks the sequence.
            if ($urandom_range(0, 5) == 0)
               add_access(ACC_READ, 1'($urandom), 8'($urandom));
            value = 8'($urandom);
            if (idx == sdcu_pkg::IDX_FER && $urandom_range(0, 3) == 0)
               value = sdcu_pkg::FER_MAGIC;
            add_access(ACC_WRITE, PORT_DATA, value);
            if ($urandom_range(0, 1) == 0)
               add_access(ACC_READ, PORT_DATA, 8'($urandom));
         end else if (kind <= 7) begin
            add_access(ACC_WRITE, PORT_INDEX, {rnd[7:5], idx});
            add_access(ACC_READ, PORT_DATA, 8'($urandom));
            add_access(ACC_READ, PORT_INDEX, 8'($urandom));
         end else begin
            repeat ($urandom_range(1, 4))
               add_access(1'($urandom), 1'($urandom), 8'($urandom));
         end
      end
      total = access_list.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < total; k++) begin
         if (k == PAUSE_AT) begin
            // Let every outstanding result drain before going on.
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (results_checked < k) @(posedge clock);
         end else if (!quiet_tail && (k / 80) % 4 != 3 && $urandom_range(0, 3) == 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         if (k >= total - CALM_TAIL)
            quiet_tail = 1'b1;
         req_bus.valid      <= 1'b1;
         req_bus.func       <= access_list[k].func;
         req_bus.port_sel   <= access_list[k].port_sel;
         req_bus.write_data <= access_list[k].write_data;
         @(posedge clock);
         while (!req_bus.ready) @(posedge clock);
      end
      req_bus.valid <= 1'b0;

      // Wait for the last results, then let the block settle.
      @(posedge clock);
      while (results_checked < total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
design/sdcu_pkg.sv
design/sdcu_if.sv
design/sdcu_regfile.sv
design/sdcu_decode.sv
design/superio_config_decoder_unit.sv
design/sdcu_checker.sv
test/tb_top.sv
